[rtl/core/mvn_pkg.sv]
// mvn_pkg: request and response types, command codes and fixed field widths
// for the vertex normal accumulate core
// no dependencies
package mvn_pkg;

   localparam int INDEX_BITS = 12;
   localparam int FIELD_BITS = 24;
   localparam int SUM_BITS   = 64;
   localparam int OUT_BITS   = 16;
   // one sum memory word: saturation mark over z, y, x sums
   localparam int SUM_WORD_BITS = 3 * SUM_BITS + 1;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_TRI  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   typedef struct packed {
      logic [1:0]                   command;
      logic [INDEX_BITS-1:0]        vertex_index;
      logic signed [FIELD_BITS-1:0] pos_x;
      logic signed [FIELD_BITS-1:0] pos_y;
      logic signed [FIELD_BITS-1:0] pos_z;
      logic [INDEX_BITS-1:0]        corner_a;
      logic [INDEX_BITS-1:0]        corner_b;
      logic [INDEX_BITS-1:0]        corner_c;
   } mvn_req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] normal_x;
      logic signed [OUT_BITS-1:0] normal_y;
      logic signed [OUT_BITS-1:0] normal_z;
      logic                       degenerate;
      logic                       saturated;
   } mvn_rsp_type;

endpackage

[rtl/core/mvn_ram.sv]
// mvn_ram: generic single-port memory with registered read
// no dependencies
module mvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or read, one access a cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/mvn_normalize.sv]
// mvn_normalize: scales a 64-bit vector sum to unit length in Q1.15
// depends on mvn_pkg; multicycle: shift search, squares, bitwise sqrt, division
module mvn_normalize (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [63:0]         sum_x,
   input  logic [63:0]         sum_y,
   input  logic [63:0]         sum_z,
   output logic                done,
   output mvn_pkg::mvn_rsp_type result
);
   import mvn_pkg::*;

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_MAX   = 3'd1;
   localparam logic [2:0] N_SHIFT = 3'd2;
   localparam logic [2:0] N_SQ    = 3'd3;
   localparam logic [2:0] N_SQRT  = 3'd4;
   localparam logic [2:0] N_DSET  = 3'd5;
   localparam logic [2:0] N_DIV   = 3'd6;
   localparam logic [2:0] N_DONE  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  neg_ff, neg_in;
   logic        degen_ff, degen_in;
   logic [63:0] mag_ff [3];
   logic [63:0] mag_in [3];
   logic [63:0] m_ff, m_in;
   logic [61:0] prod_ff, prod_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] one_ff, one_in;
   logic [63:0] res_ff, res_in;
   logic [48:0] dv_ff, dv_in;
   logic [46:0] r_ff [3];
   logic [46:0] r_in [3];
   logic [17:0] quot_ff [3];
   logic [17:0] quot_in [3];
   logic [30:0] sq_sel;
   logic [63:0] trial;
   logic [31:0] len;
   logic signed [OUT_BITS-1:0] comp [3];

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_sel = mag_ff[0][30:0];
         2'd1:    sq_sel = mag_ff[1][30:0];
         2'd2:    sq_sel = mag_ff[2][30:0];
         default: sq_sel = '0;
      endcase
   end

   assign trial = res_ff + one_ff;
   assign len   = res_ff[31:0];

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      degen_in = degen_ff;
      mag_in   = mag_ff;
      m_in     = m_ff;
      prod_in  = prod_ff;
      q_in     = q_ff;
      one_in   = one_ff;
      res_in   = res_ff;
      dv_in    = dv_ff;
      r_in     = r_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         N_IDLE: begin
            if (start) begin
               neg_in    = {sum_z[63], sum_y[63], sum_x[63]};
               mag_in[0] = sum_x[63] ? 64'd0 - sum_x : sum_x;
               mag_in[1] = sum_y[63] ? 64'd0 - sum_y : sum_y;
               mag_in[2] = sum_z[63] ? 64'd0 - sum_z : sum_z;
               state_in  = N_MAX;
            end
         end
         N_MAX: begin
            m_in = mag_ff[0];
            if (mag_ff[1] > m_in) m_in = mag_ff[1];
            if (mag_ff[2] > m_in) m_in = mag_ff[2];
            degen_in = (m_in == 64'd0);
            state_in = degen_in ? N_DONE : N_SHIFT;
         end
         // bring the largest magnitude into [2^30, 2^31)
         N_SHIFT: begin
            if (|m_ff[63:38]) begin
               m_in = m_ff >> 8;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 8;
            end else if (|m_ff[63:31]) begin
               m_in = m_ff >> 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (m_ff[63:22] == '0) begin
               m_in = m_ff << 8;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 8;
            end else if (!m_ff[30]) begin
               m_in = m_ff << 1;
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               q_in     = '0;
               state_in = N_SQ;
            end
         end
         // one square a cycle, each added to the sum in the cycle after
         N_SQ: begin
            prod_in = 62'(sq_sel) * 62'(sq_sel);
            if (cnt_ff != 5'd0) q_in = q_ff + 64'(prod_ff);
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               one_in   = 64'd1 << 62;
               res_in   = '0;
               state_in = N_SQRT;
            end
         end
         // integer square root, one result bit a cycle
         N_SQRT: begin
            if (q_ff >= trial) begin
               q_in   = q_ff - trial;
               res_in = (res_ff >> 1) + one_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            one_in = one_ff >> 2;
            if (one_ff[0]) state_in = N_DSET;
         end
         N_DSET: begin
            dv_in = {len, 17'd0};
            for (int i = 0; i < 3; i++) begin
               r_in[i]    = {mag_ff[i][30:0], 16'd0} >> 1;
               r_in[i]    = r_in[i] + 47'(len >> 1);
               quot_in[i] = '0;
            end
            cnt_in   = '0;
            state_in = N_DIV;
         end
         // restoring division, three lanes side by side
         N_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if ({2'b00, r_ff[i]} >= dv_ff) begin
                  r_in[i]    = r_ff[i] - dv_ff[46:0];
                  quot_in[i] = {quot_ff[i][16:0], 1'b1};
               end else begin
                  quot_in[i] = {quot_ff[i][16:0], 1'b0};
               end
            end
            dv_in  = dv_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd17) state_in = N_DONE;
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      degen_ff <= degen_in;
      mag_ff   <= mag_in;
      m_ff     <= m_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      one_ff   <= one_in;
      res_ff   <= res_in;
      dv_ff    <= dv_in;
      r_ff     <= r_in;
      quot_ff  <= quot_in;
   end

   // sign and clamp of each quotient
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (degen_ff) begin
            comp[i] = '0;
         end else if (neg_ff[i]) begin
            comp[i] = OUT_BITS'(18'd0 - quot_ff[i]);
         end else if (quot_ff[i] > 18'd32767) begin
            comp[i] = 16'sd32767;
         end else begin
            comp[i] = OUT_BITS'(quot_ff[i]);
         end
      end
   end

   assign done              = (state_ff == N_DONE);
   assign result.normal_x   = comp[0];
   assign result.normal_y   = comp[1];
   assign result.normal_z   = comp[2];
   assign result.degenerate = degen_ff;
   assign result.saturated  = 1'b0;

endmodule

[rtl/core/mesh_vertex_normal_accumulate_core.sv]
// mesh_vertex_normal_accumulate_core: smooth per-vertex normals of a triangle mesh
// depends on mvn_pkg, mvn_ram, mvn_normalize
//
//   channel  ports                         direction  handshake
//   request  start, busy, req_data         in         taken when start and not busy
//   result   rsp_strobe, rsp_data          out        one cycle, no back pressure
//
// A load is written in the cycle it is taken. A triangle makes three position reads, a
// cross product in the states T_MX, T_MY, T_MZ and T_SUB, then a read and a write of
// the single-port sum memory per corner. A read runs the range shift, the 32-step square
// root and the 18-step division; a read of a zero sum skips all three. After reset
// the sum memory is cleared, one entry a cycle, with busy high until all MAX_VERTICES
// entries are written. Results cannot be stalled.
module mesh_vertex_normal_accumulate_core #(
   parameter int MAX_VERTICES = 4096,
   parameter int COORD_BITS   = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mvn_pkg::mvn_req_type req_data,
   output logic                 busy,
   output logic                 rsp_strobe,
   output mvn_pkg::mvn_rsp_type rsp_data
);
   import mvn_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam logic [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_T_RB  = 4'd2;
   localparam logic [3:0] ST_T_RC  = 4'd3;
   localparam logic [3:0] ST_T_DIF = 4'd4;
   localparam logic [3:0] ST_T_MX  = 4'd5;
   localparam logic [3:0] ST_T_MY  = 4'd6;
   localparam logic [3:0] ST_T_MZ  = 4'd7;
   localparam logic [3:0] ST_T_SUB = 4'd8;
   localparam logic [3:0] ST_S_RD  = 4'd9;
   localparam logic [3:0] ST_S_WR  = 4'd10;
   localparam logic [3:0] ST_R_DAT = 4'd11;
   localparam logic [3:0] ST_R_NRM = 4'd12;

   function automatic logic in_range(logic [INDEX_BITS-1:0] v);
      return (32'(v) < 32'(MAX_VERTICES));
   endfunction

   function automatic logic signed [CW-1:0] coord(logic signed [FIELD_BITS-1:0] f);
      return CW'(f);
   endfunction

   // saturating signed add, bit 64 of the result flags saturation
   function automatic logic [64:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) begin
         return {1'b1, b[63] ? SUM_MIN : SUM_MAX};
      end
      return {1'b0, r};
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [1:0]              k_ff, k_in;
   mvn_req_type             req_ff, req_in;
   logic signed [CW-1:0]    pa_ff [3];
   logic signed [CW-1:0]    pa_in [3];
   logic signed [CW-1:0]    pb_ff [3];
   logic signed [CW-1:0]    pb_in [3];
   logic signed [DW-1:0]    d1_ff [3];
   logic signed [DW-1:0]    d1_in [3];
   logic signed [DW-1:0]    d2_ff [3];
   logic signed [DW-1:0]    d2_in [3];
   logic signed [PW-1:0]    prod0_ff, prod0_in, prod1_ff, prod1_in;
   logic signed [63:0]      n_ff [3];
   logic signed [63:0]      n_in [3];
   logic                    sat_ff, sat_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   mvn_rsp_type             rsp_ff, rsp_in;

   logic                    pos_we;
   logic [AW-1:0]           pos_addr;
   logic [3*CW-1:0]         pos_wdata, pos_rdata;
   logic signed [CW-1:0]    pos_rd [3];
   logic                    sum_we;
   logic [AW-1:0]           sum_addr;
   logic [SUM_WORD_BITS-1:0] sum_wdata, sum_rdata;
   logic [64:0]             add_x, add_y, add_z;
   logic signed [DW-1:0]    mul_a0, mul_b0, mul_a1, mul_b1;
   logic [INDEX_BITS-1:0]   corner_k;
   logic                    accept, norm_start, norm_done;
   mvn_rsp_type             norm_result;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign pos_rd[0] = pos_rdata[CW-1:0];
   assign pos_rd[1] = pos_rdata[2*CW-1:CW];
   assign pos_rd[2] = pos_rdata[3*CW-1:2*CW];

   always_comb begin
      case (k_ff)
         2'd0:    corner_k = req_ff.corner_a;
         2'd1:    corner_k = req_ff.corner_b;
         default: corner_k = req_ff.corner_c;
      endcase
   end

   // per-corner sum update
   assign add_x = sat_add(sum_rdata[63:0], n_ff[0]);
   assign add_y = sat_add(sum_rdata[127:64], n_ff[1]);
   assign add_z = sat_add(sum_rdata[191:128], n_ff[2]);

   // multiplier operands for each cross product component
   always_comb begin
      case (state_ff)
         ST_T_MX: begin
            mul_a0 = d1_ff[1]; mul_b0 = d2_ff[2]; mul_a1 = d1_ff[2]; mul_b1 = d2_ff[1];
         end
         ST_T_MY: begin
            mul_a0 = d1_ff[2]; mul_b0 = d2_ff[0]; mul_a1 = d1_ff[0]; mul_b1 = d2_ff[2];
         end
         default: begin
            mul_a0 = d1_ff[0]; mul_b0 = d2_ff[1]; mul_a1 = d1_ff[1]; mul_b1 = d2_ff[0];
         end
      endcase
   end

   // memory port control
   always_comb begin
      pos_we    = 1'b0;
      pos_addr  = AW'(req_data.corner_a);
      pos_wdata = {coord(req_data.pos_z), coord(req_data.pos_y), coord(req_data.pos_x)};
      sum_we    = 1'b0;
      sum_addr  = AW'(corner_k);
      sum_wdata = {add_x[64] | add_y[64] | add_z[64] | sum_rdata[SUM_WORD_BITS-1],
                   add_z[63:0], add_y[63:0], add_x[63:0]};
      case (state_ff)
         ST_CLEAR: begin
            sum_we    = 1'b1;
            sum_addr  = clr_ff;
            sum_wdata = '0;
         end
         ST_IDLE: begin
            sum_addr = AW'(req_data.vertex_index);
            if (accept && req_data.command == CMD_LOAD) begin
               pos_addr  = AW'(req_data.vertex_index);
               sum_wdata = '0;
               if (in_range(req_data.vertex_index)) begin
                  pos_we = 1'b1;
                  sum_we = 1'b1;
               end
            end
         end
         ST_T_RB: pos_addr = AW'(req_ff.corner_b);
         ST_T_RC: pos_addr = AW'(req_ff.corner_c);
         ST_S_WR: sum_we = 1'b1;
         default: ;
      endcase
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      k_in          = k_ff;
      req_in        = req_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      d1_in         = d1_ff;
      d2_in         = d2_ff;
      prod0_in      = prod0_ff;
      prod1_in      = prod1_ff;
      n_in          = n_ff;
      sat_in        = sat_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      norm_start    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               k_in   = '0;
               case (req_data.command)
                  CMD_TRI: begin
                     if (in_range(req_data.corner_a) && in_range(req_data.corner_b) &&
                         in_range(req_data.corner_c)) begin
                        state_in = ST_T_RB;
                     end
                  end
                  CMD_READ: begin
                     if (in_range(req_data.vertex_index)) begin
                        state_in = ST_R_DAT;
                     end else begin
                        rsp_strobe_in     = 1'b1;
                        rsp_in            = '0;
                        rsp_in.degenerate = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_T_RB: begin
            pa_in    = pos_rd;
            state_in = ST_T_RC;
         end
         ST_T_RC: begin
            pb_in    = pos_rd;
            state_in = ST_T_DIF;
         end
         ST_T_DIF: begin
            for (int i = 0; i < 3; i++) begin
               d1_in[i] = DW'(pb_ff[i]) - DW'(pa_ff[i]);
               d2_in[i] = DW'(pos_rd[i]) - DW'(pa_ff[i]);
            end
            state_in = ST_T_MX;
         end
         ST_T_MX, ST_T_MY, ST_T_MZ, ST_T_SUB: begin
            prod0_in = mul_a0 * mul_b0;
            prod1_in = mul_a1 * mul_b1;
            if (state_ff == ST_T_MY) n_in[0] = 64'(prod0_ff) - 64'(prod1_ff);
            if (state_ff == ST_T_MZ) n_in[1] = 64'(prod0_ff) - 64'(prod1_ff);
            if (state_ff == ST_T_SUB) n_in[2] = 64'(prod0_ff) - 64'(prod1_ff);
            state_in = state_ff + 4'd1;
         end
         ST_S_RD: state_in = ST_S_WR;
         ST_S_WR: begin
            k_in     = k_ff + 2'd1;
            state_in = (k_ff == 2'd2) ? ST_IDLE : ST_S_RD;
         end
         ST_R_DAT: begin
            sat_in     = sum_rdata[SUM_WORD_BITS-1];
            norm_start = 1'b1;
            state_in   = ST_R_NRM;
         end
         ST_R_NRM: begin
            if (norm_done) begin
               rsp_strobe_in    = 1'b1;
               rsp_in           = norm_result;
               rsp_in.saturated = sat_ff;
               state_in         = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      req_ff   <= req_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      d1_ff    <= d1_in;
      d2_ff    <= d2_in;
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      n_ff     <= n_in;
      sat_ff   <= sat_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // position store: z, y, x
   mvn_ram #(.WIDTH(3 * CW), .DEPTH(MAX_VERTICES)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .addr  (pos_addr),
      .wdata (pos_wdata),
      .rdata (pos_rdata)
   );

   // sum store: saturation mark, z, y, x
   mvn_ram #(.WIDTH(SUM_WORD_BITS), .DEPTH(MAX_VERTICES)) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .addr  (sum_addr),
      .wdata (sum_wdata),
      .rdata (sum_rdata)
   );

   mvn_normalize u_normalize (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .sum_x  (sum_rdata[63:0]),
      .sum_y  (sum_rdata[127:64]),
      .sum_z  (sum_rdata[191:128]),
      .done   (norm_done),
      .result (norm_result)
   );

endmodule
